// ===== design/dhcm_pkg.sv =====
// Shared types and constants for the detector hit cell merger.
// Used by dhcm_ctrl, dhcm_datapath and detector_hit_cell_merger; depends on nothing.
package dhcm_pkg;

  localparam int unsigned DHCM_TABLE_DEPTH = 256;

  localparam int unsigned CELL_W   = 64;
  localparam int unsigned ENERGY_W = 24;
  localparam int unsigned PTIME_W  = 31;
  localparam int unsigned NOISE_W  = 16;
  localparam int unsigned SLOT_W   = 8;
  localparam int unsigned CHARGE_W = 31;
  localparam int unsigned TS_W     = 32;
  // noise times weight stays within +/- 32768000, which fits 26 signed bits
  localparam int unsigned PROD_W   = 26;

  localparam logic signed [10:0]         NOISE_WEIGHT = 11'sd1000;
  localparam logic [CHARGE_W-1:0]        CHARGE_MAX   = '1;
  localparam logic signed [TS_W-1:0]     TS_MAX       = {1'b0, {(TS_W-1){1'b1}}};
  localparam logic signed [TS_W-1:0]     TS_MIN       = {1'b1, {(TS_W-1){1'b0}}};

  typedef struct packed {
    logic                       event_start;
    logic [CELL_W-1:0]          cell_id;
    logic [ENERGY_W-1:0]        energy;
    logic [PTIME_W-1:0]         particle_time;
    logic signed [NOISE_W-1:0]  time_noise;
  } dhcm_hit_t;

  typedef struct packed {
    logic [SLOT_W-1:0]          slot;
    logic [CELL_W-1:0]          hit_cell;
    logic [CHARGE_W-1:0]        charge_total;
    logic signed [TS_W-1:0]     timestamp;
    logic                       is_new;
    logic                       overflow;
  } dhcm_result_t;

  typedef struct packed {
    logic accept;
    logic search_init;
    logic search_run;
    logic commit_hit;
    logic commit_new;
  } dhcm_cmd_t;

  typedef struct packed {
    logic below_thr;
    logic match;
    logic miss;
  } dhcm_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULT,
    ST_CHECK,
    ST_SEARCH,
    ST_EMIT
  } dhcm_state_e;

endpackage

// ===== design/dhcm_ctrl.sv =====
// Sequencer of the detector hit cell merger: accept, threshold check, table scan, emit.
// Depends on dhcm_pkg; drives dhcm_datapath through command and status structs.
module dhcm_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  output logic                   result_valid_o,
  input  dhcm_pkg::dhcm_status_t status_i,
  output dhcm_pkg::dhcm_cmd_t    cmd_o
);
  import dhcm_pkg::*;

  dhcm_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_MULT;
        end
      end
      ST_MULT:  state_d = ST_CHECK;
      ST_CHECK: begin
        state_d = status_i.below_thr ? ST_IDLE : ST_SEARCH;
      end
      ST_SEARCH: begin
        if (status_i.match || status_i.miss) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    busy_o         = 1'b1;
    result_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        busy_o       = 1'b0;
        cmd_o.accept = start_i;
      end
      ST_MULT: ;
      ST_CHECK: begin
        cmd_o.search_init = !status_i.below_thr;
      end
      ST_SEARCH: begin
        cmd_o.search_run = 1'b1;
        // a match wins over the end of the scan
        cmd_o.commit_hit = status_i.match;
        cmd_o.commit_new = !status_i.match && status_i.miss;
      end
      ST_EMIT: begin
        result_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ===== design/dhcm_datapath.sv =====
// Datapath of the detector hit cell merger: threshold register, timestamp math,
// cell and charge memories with a pipelined linear scan, result register. Depends on dhcm_pkg.
module dhcm_datapath #(
  parameter int unsigned TABLE_DEPTH = dhcm_pkg::DHCM_TABLE_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dhcm_pkg::ENERGY_W-1:0]   cfg_data_i,
  input  dhcm_pkg::dhcm_hit_t             hit_i,
  input  dhcm_pkg::dhcm_cmd_t             cmd_i,
  output dhcm_pkg::dhcm_status_t          status_o,
  output dhcm_pkg::dhcm_result_t          result_o
);
  import dhcm_pkg::*;

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CntW-1:0] Full = CntW'(TABLE_DEPTH);

  logic [ENERGY_W-1:0]       thr_q;
  dhcm_hit_t                 hit_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [TS_W-1:0]    ts_q, ts_d;
  logic [CntW-1:0]           count_q;
  logic [CntW-1:0]           rd_idx_q;
  logic                      cmp_vld_q;
  logic [IdxW-1:0]           cmp_idx_q;
  logic [CELL_W-1:0]         cell_rd_q;
  logic [CHARGE_W-1:0]       chg_rd_q;
  dhcm_result_t              result_q, result_d;

  logic [CELL_W-1:0]         cell_mem [TABLE_DEPTH];
  logic [CHARGE_W-1:0]       chg_mem  [TABLE_DEPTH];

  logic                      rd_more, rd_en, full, wr_new, chg_we;
  logic [IdxW-1:0]           chg_addr;
  logic [CHARGE_W-1:0]       chg_wdata, sat_sum;
  logic [CHARGE_W:0]         sum_wide;
  logic signed [TS_W:0]      ts_wide;
  logic [IdxW+SLOT_W-1:0]    hit_slot_ext, new_slot_ext;

  assign rd_more = rd_idx_q < count_q;
  assign rd_en   = cmd_i.search_run && rd_more;
  assign full    = count_q >= Full;
  assign wr_new  = cmd_i.commit_new && !full;
  assign chg_we  = cmd_i.commit_hit || wr_new;
  assign chg_addr  = cmd_i.commit_hit ? cmp_idx_q : count_q[IdxW-1:0];
  assign chg_wdata = cmd_i.commit_hit ? sat_sum : CHARGE_W'(hit_q.energy);

  // saturating charge accumulate
  assign sum_wide = {1'b0, chg_rd_q} + (CHARGE_W + 1)'(hit_q.energy);
  assign sat_sum  = sum_wide[CHARGE_W] ? CHARGE_MAX : sum_wide[CHARGE_W-1:0];

  // smeared time, clamped to the signed 32-bit range
  assign ts_wide = $signed({2'b00, hit_q.particle_time}) + (TS_W + 1)'(prod_q);
  always_comb begin
    case (ts_wide[TS_W:TS_W-1])
      2'b01:   ts_d = TS_MAX;
      2'b10:   ts_d = TS_MIN;
      default: ts_d = ts_wide[TS_W-1:0];
    endcase
  end

  assign hit_slot_ext = {{SLOT_W{1'b0}}, cmp_idx_q};
  assign new_slot_ext = {{SLOT_W{1'b0}}, count_q[IdxW-1:0]};

  always_comb begin
    result_d              = result_q;
    result_d.hit_cell     = hit_q.cell_id;
    result_d.timestamp    = ts_q;
    if (cmd_i.commit_hit) begin
      result_d.slot         = hit_slot_ext[SLOT_W-1:0];
      result_d.charge_total = sat_sum;
      result_d.is_new       = 1'b0;
      result_d.overflow     = 1'b0;
    end else if (full) begin
      result_d.slot         = '0;
      result_d.charge_total = '0;
      result_d.is_new       = 1'b0;
      result_d.overflow     = 1'b1;
    end else begin
      result_d.slot         = new_slot_ext[SLOT_W-1:0];
      result_d.charge_total = CHARGE_W'(hit_q.energy);
      result_d.is_new       = 1'b1;
      result_d.overflow     = 1'b0;
    end
  end

  assign status_o.below_thr = hit_q.energy < thr_q;
  assign status_o.match     = cmp_vld_q && (cell_rd_q == hit_q.cell_id);
  assign status_o.miss      = !cmp_vld_q && !rd_more;
  assign result_o           = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= '0;
      count_q   <= '0;
      rd_idx_q  <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_data_i;
      end
      if (cmd_i.accept && hit_i.event_start) begin
        count_q <= '0;
      end else if (wr_new) begin
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.search_init) begin
        rd_idx_q  <= '0;
        cmp_vld_q <= 1'b0;
      end else if (cmd_i.search_run) begin
        cmp_vld_q <= rd_en;
        if (rd_en) begin
          rd_idx_q <= rd_idx_q + 1'b1;
        end
      end
    end
  end

  // payload: hold the beat, then product and clamped timestamp follow it
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      hit_q <= hit_i;
    end
    prod_q <= PROD_W'(hit_q.time_noise) * PROD_W'(NOISE_WEIGHT);
    ts_q   <= ts_d;
    if (rd_en) begin
      cmp_idx_q <= rd_idx_q[IdxW-1:0];
    end
    if (cmd_i.commit_hit || cmd_i.commit_new) begin
      result_q <= result_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      cell_rd_q <= cell_mem[rd_idx_q[IdxW-1:0]];
      chg_rd_q  <= chg_mem[rd_idx_q[IdxW-1:0]];
    end
    if (wr_new) begin
      cell_mem[count_q[IdxW-1:0]] <= hit_q.cell_id;
    end
    if (chg_we) begin
      chg_mem[chg_addr] <= chg_wdata;
    end
  end

endmodule

// ===== design/detector_hit_cell_merger.sv =====
// Top level of the detector hit cell merger: sequencer plus datapath.
// Depends on dhcm_pkg, dhcm_ctrl and dhcm_datapath.
//
// Usage:
//   A hit beat is taken at a rising edge with start_i high and busy_o low.
//   Each beat yields at most one result: result_o is shown for exactly one
//   cycle with result_valid_o high; the receiver cannot stall it.
//   A hit whose energy is below the threshold gives no result.
//   event_start in a hit empties the cell table before that hit is handled.
//   The threshold is written through cfg_valid_i/cfg_ready_o/cfg_data_i;
//   cfg_ready_o is always high; write it only while busy_o is low.
// Timing:
//   A hit below threshold keeps busy_o high through the MULT and CHECK
//   states after acceptance. Otherwise the result strobes after MULT, CHECK
//   and a scan that ends with the compare of slot k for a known cell, or
//   once all n table entries are compared for a new or dropped cell (right
//   away when the table is empty). The scan reads one cell memory entry per
//   cycle. busy_o drops the cycle after the strobe.
// Reset:
//   Empties the table and clears the threshold to zero. No clearing pass.
module detector_hit_cell_merger #(
  parameter int unsigned TABLE_DEPTH = dhcm_pkg::DHCM_TABLE_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  dhcm_pkg::dhcm_hit_t            hit_i,
  output logic                           result_valid_o,
  output dhcm_pkg::dhcm_result_t         result_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dhcm_pkg::ENERGY_W-1:0]  cfg_data_i
);
  import dhcm_pkg::*;

  dhcm_cmd_t    cmd;
  dhcm_status_t status;

  assign cfg_ready_o = 1'b1;

  dhcm_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .status_i       (status),
    .cmd_o          (cmd)
  );

  dhcm_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .hit_i      (hit_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .result_o   (result_o)
  );

endmodule
